>>> hw/rtl/phaf_pkg.sv
// Shared types and constants for the fan-triangulated polygon area unit.
// Used by every module under hw/rtl; depends on nothing.
package phaf_pkg;

	localparam int COORD_W      = 24;
	localparam int FRAC_BITS    = 8;
	localparam int MAX_VERTICES = 1024;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int DIST_W       = COORD_W + 1;
	localparam int FAC_W        = DIST_W + 3;
	localparam int MUL_W        = 27;
	localparam int PROD_W       = 2 * MUL_W;
	localparam int ACC_W        = 2 * PROD_W;
	localparam int SQ_W         = 2 * DIST_W;
	localparam int HERON_SHIFT  = 2 * FRAC_BITS + 4;
	localparam int RAD_W        = ACC_W - HERON_SHIFT;
	localparam int ROOT_W       = RAD_W / 2;
	localparam int REM_W        = ROOT_W + 2;
	localparam int AREA_W       = 48;
	localparam int TRI_W        = 10;
	localparam int ITER_W       = $clog2(ROOT_W + 1);
	localparam int SHORT_ITERS  = DIST_W;
	localparam int LONG_ITERS   = ROOT_W;

	typedef struct packed {
		logic signed [COORD_W-1:0] vert_x;
		logic signed [COORD_W-1:0] vert_y;
		logic                      last_vertex;
	} in_word_t;

	typedef struct packed {
		logic [AREA_W-1:0] total_area;
		logic [TRI_W-1:0]  triangle_count;
	} out_word_t;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_DXB,
		MUL_DYB,
		MUL_DXC,
		MUL_DYC,
		MUL_F12,
		MUL_F34,
		MUL_LL,
		MUL_LH,
		MUL_HL,
		MUL_HH
	} mul_op_t;

	typedef struct packed {
		logic    vtx_ld;
		mul_op_t mul_op;
		logic    acc_clr;
		logic    sqrt_start;
		logic    sqrt_long;
		logic    db_ld;
		logic    dc_ld;
		logic    area_ld;
		logic    commit;
		logic    emit;
	} dp_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_one;
		logic cnt_full;
		logic degen;
		logic sqrt_busy;
		logic out_busy;
		logic last;
	} dp_status_t;

endpackage

>>> hw/rtl/phaf_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
// Depends on phaf_pkg.
module phaf_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       long_mode,
	input  logic [phaf_pkg::RAD_W-1:0] rad,
	output logic                       busy,
	output logic [phaf_pkg::ROOT_W-1:0] root
);
	import phaf_pkg::*;

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [ITER_W-1:0] iter_q;
	logic [REM_W+1:0]  rem_n;
	logic [REM_W+1:0]  trial;
	logic              fits;

	assign rem_n = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits  = rem_n >= trial;
	assign busy  = iter_q != '0;
	assign root  = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (start) begin
			iter_q <= long_mode ? ITER_W'(LONG_ITERS) : ITER_W'(SHORT_ITERS);
		end else if (busy) begin
			iter_q <= iter_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= long_mode ? rad : {rad[SQ_W-1:0], {(RAD_W-SQ_W){1'b0}}};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= REM_W'(rem_n - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= REM_W'(rem_n);
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

endmodule

>>> hw/rtl/phaf_datapath.sv
// Datapath: vertex registers, shared multiplier, accumulator, area sum, output word.
// Depends on phaf_pkg and phaf_sqrt.
module phaf_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  phaf_pkg::in_word_t     in_word,
	input  phaf_pkg::dp_cmd_t      cmd,
	output phaf_pkg::dp_status_t   status,
	output logic                   out_valid,
	input  logic                   out_ready,
	output phaf_pkg::out_word_t    out_word
);
	import phaf_pkg::*;

	logic signed [COORD_W-1:0] cur_x_q, cur_y_q, first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic                      last_q;
	logic [DIST_W-1:0]         pfd_q, db_q, dc_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [AREA_W-1:0]         area_q;
	logic                      out_valid_q;
	out_word_t                 out_q;
	logic [PROD_W-1:0]         prod_s1, m1_q, m2_q;
	mul_op_t                   op_s1;
	logic [ACC_W-1:0]          acc_q;

	logic signed [DIST_W-1:0]  dxb, dyb, dxc, dyc;
	logic [DIST_W-1:0]         axb, ayb, axc, ayc;
	logic signed [FAC_W-1:0]   sa, sb, sc, f1, f2, f3, f4;
	logic [MUL_W-1:0]          mul_a, mul_b;
	logic [ACC_W-1:0]          prod_ext;
	logic                      sq_busy;
	logic [ROOT_W-1:0]         sq_root;
	logic [RAD_W-1:0]          sq_rad;
	logic [AREA_W:0]           area_add;
	logic [TRI_W-1:0]          tri_cnt;

	assign dxb = DIST_W'(prev_x_q) - DIST_W'(cur_x_q);
	assign dyb = DIST_W'(prev_y_q) - DIST_W'(cur_y_q);
	assign dxc = DIST_W'(first_x_q) - DIST_W'(cur_x_q);
	assign dyc = DIST_W'(first_y_q) - DIST_W'(cur_y_q);
	assign axb = dxb[DIST_W-1] ? DIST_W'(-dxb) : dxb;
	assign ayb = dyb[DIST_W-1] ? DIST_W'(-dyb) : dyb;
	assign axc = dxc[DIST_W-1] ? DIST_W'(-dxc) : dxc;
	assign ayc = dyc[DIST_W-1] ? DIST_W'(-dyc) : dyc;

	assign sa = FAC_W'(pfd_q);
	assign sb = FAC_W'(db_q);
	assign sc = FAC_W'(dc_q);
	assign f1 = sa + sb + sc;
	assign f2 = sb + sc - sa;
	assign f3 = sa + sc - sb;
	assign f4 = sa + sb - sc;

	always_comb begin
		unique case (cmd.mul_op)
			MUL_DXB: begin mul_a = MUL_W'(axb); mul_b = MUL_W'(axb); end
			MUL_DYB: begin mul_a = MUL_W'(ayb); mul_b = MUL_W'(ayb); end
			MUL_DXC: begin mul_a = MUL_W'(axc); mul_b = MUL_W'(axc); end
			MUL_DYC: begin mul_a = MUL_W'(ayc); mul_b = MUL_W'(ayc); end
			MUL_F12: begin mul_a = MUL_W'(f1); mul_b = MUL_W'(f2); end
			MUL_F34: begin mul_a = MUL_W'(f3); mul_b = MUL_W'(f4); end
			MUL_LL:  begin mul_a = m1_q[MUL_W-1:0]; mul_b = m2_q[MUL_W-1:0]; end
			MUL_LH:  begin mul_a = m1_q[MUL_W-1:0]; mul_b = m2_q[PROD_W-1:MUL_W]; end
			MUL_HL:  begin mul_a = m1_q[PROD_W-1:MUL_W]; mul_b = m2_q[MUL_W-1:0]; end
			MUL_HH:  begin mul_a = m1_q[PROD_W-1:MUL_W]; mul_b = m2_q[PROD_W-1:MUL_W]; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		unique case (op_s1)
			MUL_LH, MUL_HL: prod_ext = ACC_W'(prod_s1) << MUL_W;
			MUL_HH:         prod_ext = ACC_W'(prod_s1) << PROD_W;
			default:        prod_ext = ACC_W'(prod_s1);
		endcase
	end

	assign sq_rad = cmd.sqrt_long ? acc_q[ACC_W-1:HERON_SHIFT] : RAD_W'(acc_q[SQ_W-1:0]);

	phaf_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.sqrt_start),
		.long_mode (cmd.sqrt_long),
		.rad       (sq_rad),
		.busy      (sq_busy),
		.root      (sq_root)
	);

	assign area_add = {1'b0, area_q} + (AREA_W+1)'(sq_root);
	assign tri_cnt  = (cnt_q >= CNT_W'(3)) ? TRI_W'(cnt_q - CNT_W'(2)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1       <= MUL_NONE;
			cnt_q       <= '0;
			area_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			op_s1 <= cmd.mul_op;
			if (cmd.area_ld) begin
				area_q <= area_add[AREA_W] ? {AREA_W{1'b1}} : area_add[AREA_W-1:0];
			end
			if (cmd.commit && !status.cnt_full) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				cnt_q       <= '0;
				area_q      <= '0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(mul_a * mul_b);
		if (cmd.vtx_ld) begin
			cur_x_q <= in_word.vert_x;
			cur_y_q <= in_word.vert_y;
			last_q  <= in_word.last_vertex;
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else begin
			unique case (op_s1)
				MUL_DXB, MUL_DYB, MUL_DXC, MUL_DYC, MUL_LL, MUL_LH, MUL_HL, MUL_HH:
					acc_q <= acc_q + prod_ext;
				default: acc_q <= acc_q;
			endcase
		end
		if (op_s1 == MUL_F12) m1_q <= prod_s1;
		if (op_s1 == MUL_F34) m2_q <= prod_s1;
		if (cmd.db_ld) db_q <= DIST_W'(sq_root);
		if (cmd.dc_ld) dc_q <= DIST_W'(sq_root);
		if (cmd.commit && !status.cnt_full) begin
			if (status.cnt_zero) begin
				first_x_q <= cur_x_q;
				first_y_q <= cur_y_q;
				pfd_q     <= '0;
			end else begin
				pfd_q <= dc_q;
			end
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
		end
		if (cmd.emit) begin
			out_q.total_area     <= area_q;
			out_q.triangle_count <= tri_cnt;
		end
	end

	assign status.cnt_zero  = cnt_q == '0;
	assign status.cnt_one   = cnt_q == CNT_W'(1);
	assign status.cnt_full  = cnt_q >= CNT_W'(MAX_VERTICES);
	assign status.degen     = (f1 <= 0) || (f2 <= 0) || (f3 <= 0) || (f4 <= 0);
	assign status.sqrt_busy = sq_busy;
	assign status.out_busy  = out_valid_q && !out_ready;
	assign status.last      = last_q;

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

>>> hw/rtl/phaf_ctrl.sv
// Controller: sequences distances, Heron product, root and area update per vertex word.
// Depends on phaf_pkg.
module phaf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  phaf_pkg::dp_status_t status,
	output phaf_pkg::dp_cmd_t    cmd
);
	import phaf_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_BX, ST_BY, ST_BW, ST_BSQ, ST_BWAIT,
		ST_CX, ST_CY, ST_CW, ST_CSQ, ST_CWAIT, ST_FDEC,
		ST_F12, ST_F34, ST_FW, ST_LL, ST_LH, ST_HL, ST_HH, ST_HW,
		ST_HSQ, ST_HWAIT, ST_COMMIT, ST_EMIT
	} state_t;

	state_t state_q;

	assign in_ready = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:   if (in_valid) begin
					state_q <= (status.cnt_zero || status.cnt_full) ? ST_COMMIT : ST_BX;
				end
				ST_BX:     state_q <= ST_BY;
				ST_BY:     state_q <= ST_BW;
				ST_BW:     state_q <= ST_BSQ;
				ST_BSQ:    state_q <= ST_BWAIT;
				ST_BWAIT:  if (!status.sqrt_busy) state_q <= ST_CX;
				ST_CX:     state_q <= ST_CY;
				ST_CY:     state_q <= ST_CW;
				ST_CW:     state_q <= ST_CSQ;
				ST_CSQ:    state_q <= ST_CWAIT;
				ST_CWAIT:  if (!status.sqrt_busy) begin
					state_q <= status.cnt_one ? ST_COMMIT : ST_FDEC;
				end
				ST_FDEC:   state_q <= status.degen ? ST_COMMIT : ST_F12;
				ST_F12:    state_q <= ST_F34;
				ST_F34:    state_q <= ST_FW;
				ST_FW:     state_q <= ST_LL;
				ST_LL:     state_q <= ST_LH;
				ST_LH:     state_q <= ST_HL;
				ST_HL:     state_q <= ST_HH;
				ST_HH:     state_q <= ST_HW;
				ST_HW:     state_q <= ST_HSQ;
				ST_HSQ:    state_q <= ST_HWAIT;
				ST_HWAIT:  if (!status.sqrt_busy) state_q <= ST_COMMIT;
				ST_COMMIT: state_q <= status.last ? ST_EMIT : ST_IDLE;
				ST_EMIT:   if (!status.out_busy) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.mul_op = MUL_NONE;
		unique case (state_q)
			ST_IDLE:   cmd.vtx_ld = in_valid;
			ST_BX:     begin cmd.mul_op = MUL_DXB; cmd.acc_clr = 1'b1; end
			ST_BY:     cmd.mul_op = MUL_DYB;
			ST_BSQ:    cmd.sqrt_start = 1'b1;
			ST_BWAIT:  cmd.db_ld = !status.sqrt_busy;
			ST_CX:     begin cmd.mul_op = MUL_DXC; cmd.acc_clr = 1'b1; end
			ST_CY:     cmd.mul_op = MUL_DYC;
			ST_CSQ:    cmd.sqrt_start = 1'b1;
			ST_CWAIT:  cmd.dc_ld = !status.sqrt_busy;
			ST_F12:    cmd.mul_op = MUL_F12;
			ST_F34:    cmd.mul_op = MUL_F34;
			ST_FW:     cmd.acc_clr = 1'b1;
			ST_LL:     cmd.mul_op = MUL_LL;
			ST_LH:     cmd.mul_op = MUL_LH;
			ST_HL:     cmd.mul_op = MUL_HL;
			ST_HH:     cmd.mul_op = MUL_HH;
			ST_HSQ:    begin cmd.sqrt_start = 1'b1; cmd.sqrt_long = 1'b1; end
			ST_HWAIT:  cmd.area_ld = !status.sqrt_busy;
			ST_COMMIT: cmd.commit = 1'b1;
			ST_EMIT:   cmd.emit = !status.out_busy;
			default:   cmd.mul_op = MUL_NONE;
		endcase
	end

endmodule

>>> hw/rtl/polygon_area_heron_fan_unit.sv
// Polygon area by fan triangulation and Heron's formula, summed per polygon.
// Top level; depends on phaf_pkg, phaf_ctrl and phaf_datapath.
//
// Input words carry one vertex (signed Q15.8 x and y) and a last-vertex flag,
// over a valid/ready channel. Output words carry the total area (Q40.8,
// saturating) and the triangle count, one word per polygon, sent when the
// vertex flagged last has been processed.
// Per vertex word, from acceptance to in_ready high again: the first vertex
// is only stored, the second takes two 25-step distance roots, and each
// further vertex takes two distance roots, ten multiplies on the shared
// 27x27 multiplier and a 44-step root of the Heron product, all through
// the one bit-serial square root unit. A degenerate triangle skips the
// Heron product; a vertex beyond the limit skips all of the arithmetic.
// A flagged vertex then passes an emit state to load the output register.
// The output register holds a finished word while the next polygon's
// vertices are taken; if it is still full when another polygon ends, the
// unit holds in_ready low until the receiver takes the waiting word.
// Reset clears the vertex count, area sum and output valid; the unit then
// waits for a first vertex.
module polygon_area_heron_fan_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  phaf_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output phaf_pkg::out_word_t out_word
);
	import phaf_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	phaf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	phaf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule
